### rtl/ipt_pkg.sv
`timescale 1ns / 1ps
// Package for the prefix trie lookup block: field widths, codes and the command
// type passed from the front end through the queue to the walk engine.
// Depends on nothing.
package ipt_pkg;

   localparam int INDEX_BITS   = 16;
   localparam int IN_REC_BITS  = 24;
   localparam int HALF_BITS    = 64;
   localparam int FULL_BITS    = 128;
   localparam int COUNT_BITS   = 17;
   localparam int OFFSET_BITS  = 24;
   localparam int SEP_LEN      = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [0:0] REG_NUM_NODES = 1'b0;

   typedef enum logic [1:0] {
      ST_WRITTEN = 2'd0,
      ST_FOUND   = 2'd1,
      ST_MISSING = 2'd2,
      ST_BADPTR  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CMD_WRITE  = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_kind_type;

   typedef enum logic [0:0] {
      ENG_IDLE = 1'b0,
      ENG_WALK = 1'b1
   } eng_state_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic                   in_range;
      logic [INDEX_BITS-1:0]  node_index;
      logic [IN_REC_BITS-1:0] left_record;
      logic [IN_REC_BITS-1:0] right_record;
      logic [FULL_BITS-1:0]   address;
   } cmd_type;

endpackage

### rtl/ipt_req_if.sv
`timescale 1ns / 1ps
// Request channel of the prefix trie lookup block: valid, ready and one item.
// Depends on nothing.
interface ipt_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] node_index;
   logic [23:0] left_record;
   logic [23:0] right_record;
   logic [63:0] addr_high;
   logic [63:0] addr_low;

   modport source (output valid, output req_type, output node_index, output left_record,
                   output right_record, output addr_high, output addr_low, input ready);
   modport sink (input valid, input req_type, input node_index, input left_record,
                 input right_record, input addr_high, input addr_low, output ready);
endinterface

### rtl/ipt_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the prefix trie lookup block: valid, ready and one item.
// Depends on nothing.
interface ipt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [23:0] data_offset;

   modport source (output valid, output status, output data_offset, input ready);
   modport sink (input valid, input status, input data_offset, output ready);
endinterface

### rtl/ipt_csr.sv
`timescale 1ns / 1ps
// APB register block holding the node count of the trie.
// Depends on ipt_pkg.
module ipt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ipt_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ipt_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ipt_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output logic [ipt_pkg::COUNT_BITS-1:0]      num_nodes
);

   logic [ipt_pkg::COUNT_BITS-1:0] num_nodes_ff;
   logic [ipt_pkg::COUNT_BITS-1:0] num_nodes_in;
   logic                           reg_hit;

   assign reg_hit = (paddr[2] == ipt_pkg::REG_NUM_NODES);

   always_comb begin
      num_nodes_in = num_nodes_ff;
      if (psel && penable && pwrite && reg_hit) begin
         num_nodes_in = pwdata[ipt_pkg::COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff <= '0;
      end else begin
         num_nodes_ff <= num_nodes_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_hit) begin
         prdata = ipt_pkg::CSR_DATA_BITS'(num_nodes_ff);
      end
   end

   assign pready    = 1'b1;
   assign num_nodes = num_nodes_ff;

endmodule

### rtl/ipt_front.sv
`timescale 1ns / 1ps
// Front end: accepts request items, classifies them into commands and queues
// them for the walk engine. Depends on ipt_pkg and ipt_req_if.
module ipt_front #(
   parameter int NODE_DEPTH = 65536
) (
   input  logic             clock,
   input  logic             reset,
   ipt_req_if.sink          req_bus,
   output ipt_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_ready
);

   localparam logic [24:0] DEPTH_W = 25'(NODE_DEPTH);

   ipt_pkg::cmd_type new_cmd;
   ipt_pkg::cmd_type queue_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             push;
   logic             pop;

   always_comb begin
      new_cmd.kind         = req_bus.req_type ? ipt_pkg::CMD_LOOKUP : ipt_pkg::CMD_WRITE;
      new_cmd.in_range     = (25'(req_bus.node_index) < DEPTH_W);
      new_cmd.node_index   = req_bus.node_index;
      new_cmd.left_record  = req_bus.left_record;
      new_cmd.right_record = req_bus.right_record;
      new_cmd.address      = {req_bus.addr_high, req_bus.addr_low};
   end

   assign req_bus.ready = (count_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign cmd_valid     = (count_ff != 2'd0);
   assign pop           = cmd_valid && cmd_ready;
   assign cmd           = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### rtl/ipt_engine.sv
`timescale 1ns / 1ps
// Walk engine: holds the node memory, stores nodes and walks the trie one
// level per cycle, then registers the response. Depends on ipt_pkg and ipt_rsp_if.
module ipt_engine #(
   parameter int NODE_DEPTH  = 65536,
   parameter int RECORD_BITS = 24,
   parameter int ADDR_BITS   = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ipt_pkg::COUNT_BITS-1:0]  num_nodes,
   input  ipt_pkg::cmd_type                cmd,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   ipt_rsp_if.source                       rsp_bus
);

   localparam int NODE_AW = $clog2(NODE_DEPTH);
   localparam int CW      = RECORD_BITS + 1;
   localparam int LVL_W   = $clog2(ADDR_BITS);
   localparam logic [CW-1:0]    DEPTH_C  = CW'(NODE_DEPTH);
   localparam logic [CW-1:0]    SEP_C    = CW'(ipt_pkg::SEP_LEN);
   localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(ADDR_BITS - 1);

   logic [2*RECORD_BITS-1:0] node_mem [NODE_DEPTH];
   logic [2*RECORD_BITS-1:0] entry_ff;

   ipt_pkg::eng_state_type state_ff;
   ipt_pkg::eng_state_type state_in;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic [ADDR_BITS-1:0]   addr_in;
   logic [LVL_W-1:0]       lvl_ff;
   logic [LVL_W-1:0]       lvl_in;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   ipt_pkg::status_type            status_ff;
   ipt_pkg::status_type            status_in;
   logic [ipt_pkg::OFFSET_BITS-1:0] offset_ff;
   logic [ipt_pkg::OFFSET_BITS-1:0] offset_in;

   logic                 out_free;
   logic                 mem_we;
   logic [NODE_AW-1:0]   wr_addr;
   logic [NODE_AW-1:0]   rd_addr;
   logic                 start_walk;
   logic                 step;
   logic                 load_res;
   ipt_pkg::status_type  res_status;
   logic [ipt_pkg::OFFSET_BITS-1:0] res_offset;

   logic [RECORD_BITS-1:0] rec;
   logic [CW-1:0]          rec_c;
   logic [CW-1:0]          nc_c;
   logic [CW-1:0]          sep_end;
   logic [CW-1:0]          offset_full;
   logic                   eval_done;
   ipt_pkg::status_type    eval_status;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign wr_addr  = NODE_AW'(cmd.node_index);

   always_comb begin
      rec         = addr_ff[ADDR_BITS-1] ? entry_ff[2*RECORD_BITS-1:RECORD_BITS]
                                         : entry_ff[RECORD_BITS-1:0];
      rec_c       = CW'(rec);
      nc_c        = CW'(num_nodes);
      sep_end     = nc_c + SEP_C;
      offset_full = rec_c - sep_end;
      eval_done   = 1'b1;
      eval_status = ipt_pkg::ST_MISSING;
      if (rec_c == nc_c) begin
         eval_status = ipt_pkg::ST_MISSING;
      end else if (rec_c > nc_c) begin
         eval_status = (rec_c < sep_end) ? ipt_pkg::ST_BADPTR : ipt_pkg::ST_FOUND;
      end else if (rec_c >= DEPTH_C) begin
         eval_status = ipt_pkg::ST_BADPTR;
      end else if (lvl_ff == LAST_LVL) begin
         eval_status = ipt_pkg::ST_MISSING;
      end else begin
         eval_done = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ipt_pkg::ENG_IDLE: begin
            if (cmd_valid && out_free && (cmd.kind == ipt_pkg::CMD_LOOKUP)) begin
               state_in = ipt_pkg::ENG_WALK;
            end
         end
         ipt_pkg::ENG_WALK: begin
            if (eval_done) begin
               state_in = ipt_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = ipt_pkg::ENG_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_ready  = 1'b0;
      mem_we     = 1'b0;
      rd_addr    = '0;
      start_walk = 1'b0;
      step       = 1'b0;
      load_res   = 1'b0;
      res_status = ipt_pkg::ST_WRITTEN;
      res_offset = '0;
      case (state_ff)
         ipt_pkg::ENG_IDLE: begin
            cmd_ready = out_free;
            if (cmd_valid && out_free) begin
               if (cmd.kind == ipt_pkg::CMD_WRITE) begin
                  mem_we   = cmd.in_range;
                  load_res = 1'b1;
               end else begin
                  start_walk = 1'b1;
               end
            end
         end
         ipt_pkg::ENG_WALK: begin
            if (eval_done) begin
               load_res   = 1'b1;
               res_status = eval_status;
               if (eval_status == ipt_pkg::ST_FOUND) begin
                  res_offset = offset_full[ipt_pkg::OFFSET_BITS-1:0];
               end
            end else begin
               step    = 1'b1;
               rd_addr = rec[NODE_AW-1:0];
            end
         end
         default: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      addr_in = addr_ff;
      lvl_in  = lvl_ff;
      if (start_walk) begin
         addr_in = cmd.address[ADDR_BITS-1:0];
         lvl_in  = '0;
      end else if (step) begin
         addr_in = {addr_ff[ADDR_BITS-2:0], 1'b0};
         lvl_in  = lvl_ff + LVL_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      offset_in    = offset_ff;
      if (load_res) begin
         rsp_valid_in = 1'b1;
         status_in    = res_status;
         offset_in    = res_offset;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipt_pkg::ENG_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      lvl_ff    <= lvl_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[wr_addr] <= {RECORD_BITS'(cmd.right_record), RECORD_BITS'(cmd.left_record)};
      end
      entry_ff <= node_mem[rd_addr];
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.data_offset = offset_ff;

endmodule

### rtl/ip_prefix_trie_lookup.sv
`timescale 1ns / 1ps
// Binary trie lookup over 128-bit addresses with a node memory loaded by writes.
// Depends on ipt_pkg, ipt_req_if, ipt_rsp_if, ipt_csr, ipt_front and ipt_engine.
//
// Usage: the node count is set through the APB port while the block is idle.
// Request items on req_bus either store one node (req_type 0) or look up
// an address (req_type 1). Every request item yields exactly one response
// item on rsp_bus, in order, carrying a status and a data offset.
// Requests enter a two-entry queue, so up to two items are taken while the
// engine is busy or the response waits to be taken.
// A write is handled by the engine in its idle state. A lookup starts from the
// idle state and then walks one trie level per cycle, at most one level per
// address bit, with one node memory read per level.
// The response is registered: it appears in the cycle after the engine ends
// the item and stays until rsp_bus.ready is high. While it waits, the engine
// starts no new item and the queue fills, then req_bus.ready drops.
// Synchronous reset empties the queue, drops any response and clears
// the node count; the node memory is not cleared and holds no valid nodes
// until written.
module ip_prefix_trie_lookup #(
   parameter int NODE_DEPTH  = 65536,
   parameter int RECORD_BITS = 24,
   parameter int ADDR_BITS   = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   ipt_req_if.sink                            req_bus,
   ipt_rsp_if.source                          rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ipt_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [ipt_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [ipt_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   logic [ipt_pkg::COUNT_BITS-1:0] num_nodes;
   ipt_pkg::cmd_type               cmd;
   logic                           cmd_valid;
   logic                           cmd_ready;

   ipt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .num_nodes (num_nodes)
   );

   ipt_front #(
      .NODE_DEPTH (NODE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   ipt_engine #(
      .NODE_DEPTH  (NODE_DEPTH),
      .RECORD_BITS (RECORD_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .num_nodes  (num_nodes),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

### test/ip_prefix_trie_lookup_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ip_prefix_trie_lookup: loads trie nodes, sets the node
// count over APB and compares every response item with a trie walk done here.
// Depends on ipt_pkg, ipt_req_if, ipt_rsp_if and the ip_prefix_trie_lookup RTL.
module ip_prefix_trie_lookup_tb;

   localparam int          NODE_DEPTH     = 65536;
   localparam int          IDLE_PCT       = 19;
   localparam int          HOLDOFF_CYCLES = 300;
   localparam int          QUIET_LIMIT    = 2000;
   localparam int          SETTLE_CYCLES  = 4;
   localparam logic [0:0]  REG_SPARE      = 1'b1;

   typedef logic [ipt_pkg::IN_REC_BITS-1:0] record_type;
   typedef logic [ipt_pkg::INDEX_BITS-1:0]  index_type;
   typedef logic [ipt_pkg::OFFSET_BITS-1:0] offset_type;

   typedef struct {
      ipt_pkg::status_type status;
      offset_type          offset;
   } walk_result_type;

   typedef struct {
      ipt_pkg::cmd_kind_type          kind;
      index_type                      index;
      record_type                     left;
      record_type                     right;
      logic [ipt_pkg::FULL_BITS-1:0]  address;
   } trie_request_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [ipt_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [ipt_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [ipt_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   ipt_req_if req_bus();
   ipt_rsp_if rsp_bus();

   logic [2*ipt_pkg::IN_REC_BITS-1:0] trie_nodes [0:NODE_DEPTH-1];
   int unsigned                       tree_size;
   int unsigned                       phase_nodes[$];
   bit                                in_phase [0:NODE_DEPTH-1];
   walk_result_type                   results_due[$];
   int                                mismatches;
   int                                holdoff_requests;
   bit                                steady;

   ip_prefix_trie_lookup i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic walk_result_type trie_walk(
      input logic [ipt_pkg::FULL_BITS-1:0] address);
      walk_result_type                   res;
      int unsigned                       node;
      int unsigned                       rec;
      int                                level;
      logic [2*ipt_pkg::IN_REC_BITS-1:0] entry;
      res.status = ipt_pkg::ST_MISSING;
      res.offset = '0;
      node = 0;
      for (level = ipt_pkg::FULL_BITS - 1; level >= 0; level--) begin
         entry = trie_nodes[node[ipt_pkg::INDEX_BITS-1:0]];
         rec = address[level] ? 32'(entry[2*ipt_pkg::IN_REC_BITS-1:ipt_pkg::IN_REC_BITS])
                              : 32'(entry[ipt_pkg::IN_REC_BITS-1:0]);
         if (rec == tree_size) begin
            return res;
         end
         if (rec > tree_size) begin
            if (rec < tree_size + ipt_pkg::SEP_LEN) begin
               res.status = ipt_pkg::ST_BADPTR;
            end else begin
               res.status = ipt_pkg::ST_FOUND;
               res.offset = offset_type'(rec - tree_size - ipt_pkg::SEP_LEN);
            end
            return res;
         end
         if (rec >= NODE_DEPTH) begin
            res.status = ipt_pkg::ST_BADPTR;
            return res;
         end
         node = rec;
      end
      return res;
   endfunction

   function automatic logic [ipt_pkg::FULL_BITS-1:0] random_address();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return {{ipt_pkg::FULL_BITS-1{1'b0}}, 1'b1} << $urandom_range(ipt_pkg::FULL_BITS - 1);
         default: return {$urandom, $urandom, $urandom, $urandom};
      endcase
   endfunction

   function automatic record_type pick_record(input int unsigned link_pct);
      if (tree_size > 0 && $urandom_range(99) < link_pct) begin
         return record_type'(phase_nodes[$urandom_range(phase_nodes.size() - 1)]);
      end
      case ($urandom_range(7))
         0: return record_type'(tree_size);
         1: return record_type'(tree_size + $urandom_range(1, ipt_pkg::SEP_LEN - 1));
         2: return (tree_size > NODE_DEPTH)
                   ? record_type'($urandom_range(NODE_DEPTH, tree_size - 1))
                   : 24'hFFFFFF;
         3: return 24'hFFFFFF;
         default: return record_type'($urandom_range(tree_size + ipt_pkg::SEP_LEN, 24'hFFFFFF));
      endcase
   endfunction

   function automatic trie_request_type node_write(input int unsigned index,
                                                   input record_type  left,
                                                   input record_type  right);
      trie_request_type rq;
      rq.kind    = ipt_pkg::CMD_WRITE;
      rq.index   = index_type'(index);
      rq.left    = left;
      rq.right   = right;
      rq.address = random_address();
      return rq;
   endfunction

   function automatic trie_request_type lookup_of(
      input logic [ipt_pkg::FULL_BITS-1:0] address);
      trie_request_type rq;
      rq.kind    = ipt_pkg::CMD_LOOKUP;
      rq.index   = index_type'($urandom);
      rq.left    = record_type'($urandom);
      rq.right   = record_type'($urandom);
      rq.address = address;
      return rq;
   endfunction

   task automatic send_item(input trie_request_type rq);
      walk_result_type res;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= rq.kind;
      req_bus.node_index   <= rq.index;
      req_bus.left_record  <= rq.left;
      req_bus.right_record <= rq.right;
      req_bus.addr_high    <= rq.address[ipt_pkg::FULL_BITS-1:ipt_pkg::HALF_BITS];
      req_bus.addr_low     <= rq.address[ipt_pkg::HALF_BITS-1:0];
      do @(posedge clock); while (!req_bus.ready);
      if (rq.kind == ipt_pkg::CMD_WRITE) begin
         trie_nodes[rq.index] = {rq.right, rq.left};
         res.status = ipt_pkg::ST_WRITTEN;
         res.offset = '0;
      end else begin
         res = trie_walk(rq.address);
      end
      results_due.push_back(res);
      @(negedge clock);
   endtask

   // Mostly lookups over the current tree, with writes to random nodes, some of them in the tree.
   task automatic send_mixed_item(input int unsigned link_pct);
      int unsigned index;
      if ($urandom_range(9) == 0) begin
         index = $urandom_range(NODE_DEPTH - 1);
         if (in_phase[index[ipt_pkg::INDEX_BITS-1:0]]) begin
            send_item(node_write(index, pick_record(link_pct), pick_record(link_pct)));
         end else begin
            send_item(node_write(index, record_type'($urandom), record_type'($urandom)));
         end
      end else begin
         send_item(lookup_of(random_address()));
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [0:0] index,
                            input logic [ipt_pkg::CSR_DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (index == ipt_pkg::REG_NUM_NODES) begin
         tree_size = 32'(value[ipt_pkg::COUNT_BITS-1:0]);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_tree_size();
      logic [ipt_pkg::CSR_DATA_BITS-1:0] word;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {ipt_pkg::REG_NUM_NODES, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      word = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (word[ipt_pkg::COUNT_BITS-1:0] !== tree_size[ipt_pkg::COUNT_BITS-1:0]) begin
         $error("node count: expected %0d, actual %0d", tree_size,
                word[ipt_pkg::COUNT_BITS-1:0]);
         mismatches++;
      end
   endtask

   task automatic set_tree_size(input int unsigned size);
      drain();
      csr_write(ipt_pkg::REG_NUM_NODES, size);
      check_tree_size();
   endtask

   task automatic test_directed_trees();
      check_tree_size();

      set_tree_size(0);
      send_item(node_write(0, 24'd0, 24'd15));
      send_item(lookup_of('0));
      send_item(lookup_of('1));
      send_item(node_write(0, 24'd16, 24'hFFFFFF));
      send_item(lookup_of('0));
      send_item(lookup_of('1));

      // Node 3 loops on itself, so a run of zero bits uses up the rest of the address.
      set_tree_size(4);
      send_item(node_write(0, 24'd1, 24'd2));
      send_item(node_write(1, 24'd4, 24'd19));
      send_item(node_write(2, 24'd3, 24'd20));
      send_item(node_write(3, 24'd3, 24'hFFFFFF));
      send_item(lookup_of('0));
      send_item(lookup_of({64'h4000_0000_0000_0000, 64'h0}));
      send_item(lookup_of({64'h8000_0000_0000_0000, 64'h0}));
      send_item(lookup_of({64'hC000_0000_0000_0000, 64'h0}));
      send_item(lookup_of({64'h8000_0000_0000_0000, 64'h1}));

      set_tree_size(NODE_DEPTH);
      send_item(node_write(0, record_type'(NODE_DEPTH - 1), record_type'(NODE_DEPTH)));
      send_item(node_write(NODE_DEPTH - 1, record_type'(NODE_DEPTH + ipt_pkg::SEP_LEN),
                           24'd0));
      send_item(lookup_of('0));
      send_item(lookup_of({64'h4000_0000_0000_0000, 64'h0}));
      send_item(lookup_of('1));

      // With the node count above the memory depth, a link past the last node is a bad pointer.
      set_tree_size(2**ipt_pkg::COUNT_BITS - 1);
      send_item(node_write(0, record_type'(NODE_DEPTH),
                           record_type'(2**ipt_pkg::COUNT_BITS - 1)));
      send_item(lookup_of('0));
      send_item(lookup_of('1));
      drain();
      csr_write(REG_SPARE, 32'd5);
      check_tree_size();
      send_item(node_write(0, record_type'(2**ipt_pkg::COUNT_BITS - 1 + ipt_pkg::SEP_LEN),
                           record_type'(2**ipt_pkg::COUNT_BITS - 2 + ipt_pkg::SEP_LEN)));
      send_item(lookup_of('0));
      send_item(lookup_of('1));
   endtask

   task automatic grow_phase(input int unsigned size, input int unsigned link_pct,
                             input int lookups);
      int unsigned span;
      int unsigned index;
      set_tree_size(size);
      foreach (phase_nodes[i]) in_phase[phase_nodes[i][ipt_pkg::INDEX_BITS-1:0]] = 1'b0;
      phase_nodes.delete();
      if (size <= 64) begin
         span = (size == 0) ? 1 : size;
         for (index = 0; index < span; index++) begin
            phase_nodes.push_back(index);
            in_phase[index[ipt_pkg::INDEX_BITS-1:0]] = 1'b1;
         end
      end else begin
         span = (size < NODE_DEPTH) ? size : NODE_DEPTH;
         phase_nodes.push_back(0);
         in_phase[0] = 1'b1;
         while (phase_nodes.size() < 16) begin
            index = $urandom_range(span - 1);
            if (!in_phase[index[ipt_pkg::INDEX_BITS-1:0]]) begin
               phase_nodes.push_back(index);
               in_phase[index[ipt_pkg::INDEX_BITS-1:0]] = 1'b1;
            end
         end
      end
      foreach (phase_nodes[i]) begin
         send_item(node_write(phase_nodes[i], pick_record(link_pct), pick_record(link_pct)));
      end
      repeat (lookups) send_mixed_item(link_pct);
   endtask

   task automatic test_random_trees();
      int unsigned sizes[12]   = '{1, 2, 8, 33, 64, 0, 65536, 131071, 20, 5, 40000, 48};
      int unsigned links[12]   = '{80, 60, 85, 70, 95, 0, 70, 60, 97, 50, 75, 90};
      int          lookups[12] = '{35, 35, 45, 45, 45, 20, 35, 30, 45, 40, 30, 40};
      foreach (sizes[i]) grow_phase(sizes[i], links[i], lookups[i]);
   endtask

   task automatic test_receiver_holdoff();
      holdoff_requests++;
      repeat (24) send_mixed_item(90);
      drain();
   endtask

   task automatic test_sender_pause();
      repeat (3) begin
         repeat (8) send_mixed_item(90);
         drain();
      end
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      repeat (100) send_mixed_item(90);
      drain();
      steady = 1'b0;
   endtask

   initial begin : response_pacing
      int holdoff_left;
      int served;
      rsp_bus.ready = 1'b0;
      holdoff_left  = 0;
      served        = 0;
      forever begin
         @(negedge clock);
         if (served != holdoff_requests) begin
            served       = holdoff_requests;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : check_responses
      walk_result_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (results_due.size() == 0) begin
            $error("status: expected no item, actual %0d", rsp_bus.status);
            mismatches++;
         end else begin
            due = results_due.pop_front();
            if (rsp_bus.status !== due.status) begin
               $error("status: expected %0d, actual %0d", due.status, rsp_bus.status);
               mismatches++;
            end
            if (rsp_bus.data_offset !== due.offset) begin
               $error("data_offset: expected %0d, actual %0d", due.offset,
                      rsp_bus.data_offset);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = 1'b0;
      req_bus.node_index   = '0;
      req_bus.left_record  = '0;
      req_bus.right_record = '0;
      req_bus.addr_high    = '0;
      req_bus.addr_low     = '0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      tree_size            = 0;
      mismatches           = 0;
      holdoff_requests     = 0;
      steady               = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_trees();
      test_random_trees();
      test_receiver_holdoff();
      test_sender_pause();
      test_steady_stream();
      drain();

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

### ip_prefix_trie_lookup.f
rtl/ipt_pkg.sv
rtl/ipt_req_if.sv
rtl/ipt_rsp_if.sv
rtl/ipt_csr.sv
rtl/ipt_front.sv
rtl/ipt_engine.sv
rtl/ip_prefix_trie_lookup.sv
test/ip_prefix_trie_lookup_tb.sv
